/* rtl/binodal_phase_classifier_unit_macros.svh */
// Assertion macros shared by the binodal phase classifier RTL.
`ifndef BINODAL_PHASE_CLASSIFIER_UNIT_MACROS_SVH
`define BINODAL_PHASE_CLASSIFIER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpc assertion failed");

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpc assertion failed");

`else

`define BPC_ASSERT_IMP(label, clk, rst, ante, cons)
`define BPC_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/bpc_pkg.sv */
// Shared types and constants of the binodal phase classifier.
`default_nettype none

package bpc_pkg;

   localparam int VAL_W               = 32;
   localparam int FRAC_W              = 16;
   localparam int ROW_IDX_W           = 6;
   localparam int PHASE_W             = 3;
   localparam int ROWS_W              = 7;
   localparam int CSR_IDX_W           = 2;
   localparam int DEFAULT_TABLE_DEPTH = 64;

   // Request commands
   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   // Phase codes
   localparam logic [PHASE_W-1:0] PHASE_NOT_SET   = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_GAS       = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_SCF       = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_LIQUID    = 3'd3;
   localparam logic [PHASE_W-1:0] PHASE_LIQ_STEAM = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CRIT_TEMP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRIT_PRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CRIT_VOL   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS       = 2'd3;

   // One in Q1.16, one bit wider than the quotient
   localparam logic [FRAC_W:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

   typedef struct packed {
      logic [VAL_W-1:0] pressure;
      logic [VAL_W-1:0] left_volume;
      logic [VAL_W-1:0] right_volume;
   } row_type;

   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] num;
      logic [VAL_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quo;
   } div_rsp_type;

endpackage

`default_nettype wire

/* rtl/bpc_table.sv */
// Binodal curve table: one synchronous row memory, one write and one read port.
`default_nettype none

module bpc_table #(
   parameter int TABLE_DEPTH = bpc_pkg::DEFAULT_TABLE_DEPTH,
   parameter int AW          = $clog2(TABLE_DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire bpc_pkg::row_type wr_row,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output bpc_pkg::row_type      rd_row
);
   import bpc_pkg::*;

   row_type mem [TABLE_DEPTH];
   row_type rd_row_ff;

   // Write one row per load request
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

`default_nettype wire

/* rtl/bpc_divider.sv */
// Restoring divider: Q0.16 quotient of num / den with num below den.
`default_nettype none

`include "binodal_phase_classifier_unit_macros.svh"

module bpc_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bpc_pkg::div_req_type req,
   output bpc_pkg::div_rsp_type      rsp
);
   import bpc_pkg::*;

   localparam int CNT_W = $clog2(FRAC_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [VAL_W-1:0]  rem_ff, rem_in;
   logic [VAL_W-1:0]  den_ff, den_in;
   logic [FRAC_W-1:0] quo_ff, quo_in;
   logic [VAL_W:0]    shifted;
   logic              fits;

   // One quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, 1'b0};
      fits    = (shifted >= {1'b0, den_ff});
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(FRAC_W);
         rem_in  = req.num;
         den_in  = req.den;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = VAL_W'(shifted - {1'b0, den_ff});
         end else begin
            rem_in = shifted[VAL_W-1:0];
         end
         quo_in = {quo_ff[FRAC_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

   `BPC_ASSERT_NXT(a_div_start_busy, clock, reset, req.start, busy_ff)
   `BPC_ASSERT_IMP(a_div_rem_below, clock, reset, busy_ff, rem_ff < den_ff)
   `BPC_ASSERT_IMP(a_div_done_idle, clock, reset, done_ff, !busy_ff && cnt_ff == '0)

endmodule

`default_nettype wire

/* rtl/binodal_phase_classifier_unit.sv */
// Top level of the binodal phase classifier: request decode, scan sequencer, interpolation.
//
//   channel   ports                   handshake
//   request   start, busy, req_*      taken when start is high and busy is low
//   result    rsp_valid, rsp_phase    one-cycle strobe, cannot be held off
//   config    csr_write_enable, ...   written at any edge with enable high
//
// A load request leaves busy low; the row is written as the request is taken.
// A classify request with no table, or at or above the critical temperature,
// answers in the next cycle without raising busy.
// Otherwise the sequencer reads the table one row per cycle from the single
// read port; on a matching row it runs the serial divider, skipped when the
// fraction is one, then a multiply and add. Reset clears control state;
// table rows are not cleared.
`default_nettype none

`include "binodal_phase_classifier_unit_macros.svh"

module binodal_phase_classifier_unit #(
   parameter int TABLE_DEPTH = bpc_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_command,
   input  wire logic [bpc_pkg::ROW_IDX_W-1:0]   req_row_index,
   input  wire logic [bpc_pkg::VAL_W-1:0]       req_row_pressure,
   input  wire logic [bpc_pkg::VAL_W-1:0]       req_row_left_volume,
   input  wire logic [bpc_pkg::VAL_W-1:0]       req_row_right_volume,
   input  wire logic [bpc_pkg::VAL_W-1:0]       req_point_volume,
   input  wire logic [bpc_pkg::VAL_W-1:0]       req_point_pressure,
   input  wire logic [bpc_pkg::VAL_W-1:0]       req_point_temperature,
   output logic                                 rsp_valid,
   output logic [bpc_pkg::PHASE_W-1:0]          rsp_phase,
   input  wire logic                            csr_write_enable,
   input  wire logic [bpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bpc_pkg::VAL_W-1:0]       csr_data
);
   import bpc_pkg::*;

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int MW    = (CNT_W > ROWS_W) ? CNT_W : ROWS_W;
   localparam int PROD_W = VAL_W + FRAC_W + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRIME = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_FRAC  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_MUL   = 3'd5;
   localparam logic [2:0] ST_ADD   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   // Configuration registers
   logic [VAL_W-1:0]  crit_temp_ff, crit_press_ff, crit_vol_ff;
   logic [ROWS_W-1:0] rows_ff;

   // Sequencer state
   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     row_ff, row_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0] rsp_phase_ff, rsp_phase_in;

   // Datapath registers
   logic [VAL_W-1:0]  pt_vol_ff, pt_vol_in;
   logic [VAL_W-1:0]  pt_press_ff, pt_press_in;
   logic              left_ff, left_in;
   logic [VAL_W-1:0]  prev_p_ff, prev_p_in;
   logic [VAL_W-1:0]  prev_v_ff, prev_v_in;
   logic [VAL_W-1:0]  near_p_ff, near_p_in;
   logic [VAL_W-1:0]  near_v_ff, near_v_in;
   logic [VAL_W-1:0]  diff_ff, diff_in;
   logic              up_ff, up_in;
   logic [FRAC_W:0]   frac_ff, frac_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [VAL_W-1:0]  bound_ff, bound_in;

   // Table and divider links
   logic              accept;
   logic              tbl_wr_en;
   row_type           tbl_wr_row;
   logic              tbl_rd_en;
   logic [AW-1:0]     tbl_rd_addr;
   row_type           tbl_rd_row;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic [MW-1:0]     rows_ext;
   logic [AW-1:0]     n_last;
   logic              no_table;
   logic [VAL_W-1:0]  row_branch;
   logic [VAL_W-1:0]  num;
   logic [VAL_W-1:0]  den;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Clip the row count to the table depth; keep the index of the last row
   assign rows_ext = MW'(rows_ff);
   assign no_table = (rows_ff == '0);
   always_comb begin
      if (rows_ext > MW'(TABLE_DEPTH)) begin
         n_last = AW'(TABLE_DEPTH - 1);
      end else begin
         n_last = AW'(rows_ext - MW'(1));
      end
   end

   // Write a row on each load request inside the table
   assign tbl_wr_en = accept && (req_command == CMD_LOAD) &&
                      ({{(32 - ROW_IDX_W){1'b0}}, req_row_index} < 32'(TABLE_DEPTH));
   assign tbl_wr_row.pressure     = req_row_pressure;
   assign tbl_wr_row.left_volume  = req_row_left_volume;
   assign tbl_wr_row.right_volume = req_row_right_volume;

   // Read row 0 while priming, then the row after the one arriving
   assign tbl_rd_en   = (state_ff inside {ST_PRIME, ST_SCAN});
   assign tbl_rd_addr = (state_ff == ST_SCAN) ? AW'(row_ff + 1'b1) : '0;

   bpc_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (AW'(req_row_index)),
      .wr_row  (tbl_wr_row),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_row  (tbl_rd_row)
   );

   assign row_branch = left_ff ? tbl_rd_row.left_volume : tbl_rd_row.right_volume;
   assign num        = pt_press_ff - near_p_ff;
   assign den        = prev_p_ff - near_p_ff;

   assign div_req.start = (state_ff == ST_FRAC) && (prev_p_ff > near_p_ff) && (num < den);
   assign div_req.num   = num;
   assign div_req.den   = den;

   bpc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      rsp_valid_in = 1'b0;
      rsp_phase_in = rsp_phase_ff;
      pt_vol_in    = pt_vol_ff;
      pt_press_in  = pt_press_ff;
      left_in      = left_ff;
      prev_p_in    = prev_p_ff;
      prev_v_in    = prev_v_ff;
      near_p_in    = near_p_ff;
      near_v_in    = near_v_ff;
      diff_in      = diff_ff;
      up_in        = up_ff;
      frac_in      = frac_ff;
      prod_in      = prod_ff;
      bound_in     = bound_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_CLASSIFY)) begin
               pt_vol_in   = req_point_volume;
               pt_press_in = req_point_pressure;
               left_in     = (req_point_volume < crit_vol_ff);
               if (no_table) begin
                  rsp_valid_in = 1'b1;
                  rsp_phase_in = PHASE_NOT_SET;
               end else if (req_point_temperature >= crit_temp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_phase_in = (req_point_pressure >= crit_press_ff) ? PHASE_SCF
                                                                        : PHASE_GAS;
               end else begin
                  state_in = ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            row_in   = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Stop at the first row past row 0 below the point pressure
            if ((row_ff != '0) && (tbl_rd_row.pressure < pt_press_ff)) begin
               near_p_in = tbl_rd_row.pressure;
               near_v_in = row_branch;
               state_in  = ST_FRAC;
            end else if (row_ff == n_last) begin
               rsp_valid_in = 1'b1;
               rsp_phase_in = (pt_vol_ff <= crit_vol_ff) ? PHASE_LIQ_STEAM : PHASE_GAS;
               state_in     = ST_IDLE;
            end else begin
               prev_p_in = tbl_rd_row.pressure;
               prev_v_in = row_branch;
               row_in    = AW'(row_ff + 1'b1);
            end
         end
         ST_FRAC: begin
            up_in   = (prev_v_ff >= near_v_ff);
            diff_in = (prev_v_ff >= near_v_ff) ? (prev_v_ff - near_v_ff)
                                               : (near_v_ff - prev_v_ff);
            if (div_req.start) begin
               state_in = ST_DIV;
            end else begin
               frac_in  = FRAC_ONE;
               state_in = ST_MUL;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               frac_in  = {1'b0, div_rsp.quo};
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(diff_ff) * PROD_W'(frac_ff);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (up_ff) begin
               bound_in = near_v_ff + prod_ff[FRAC_W +: VAL_W];
            end else begin
               bound_in = near_v_ff - prod_ff[FRAC_W +: VAL_W];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            if (left_ff) begin
               rsp_phase_in = (pt_vol_ff < bound_ff) ? PHASE_LIQUID : PHASE_LIQ_STEAM;
            end else begin
               rsp_phase_in = (pt_vol_ff > bound_ff) ? PHASE_GAS : PHASE_LIQ_STEAM;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_phase_ff <= rsp_phase_in;
      pt_vol_ff    <= pt_vol_in;
      pt_press_ff  <= pt_press_in;
      left_ff      <= left_in;
      prev_p_ff    <= prev_p_in;
      prev_v_ff    <= prev_v_in;
      near_p_ff    <= near_p_in;
      near_v_ff    <= near_v_in;
      diff_ff      <= diff_in;
      up_ff        <= up_in;
      frac_ff      <= frac_in;
      prod_ff      <= prod_in;
      bound_ff     <= bound_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         crit_temp_ff  <= '0;
         crit_press_ff <= '0;
         crit_vol_ff   <= '0;
         rows_ff       <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CRIT_TEMP:  crit_temp_ff  <= csr_data;
            CSR_CRIT_PRESS: crit_press_ff <= csr_data;
            CSR_CRIT_VOL:   crit_vol_ff   <= csr_data;
            CSR_ROWS:       rows_ff       <= csr_data[ROWS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_phase = rsp_phase_ff;

   `BPC_ASSERT_NXT(a_load_no_rsp, clock, reset, accept && req_command == CMD_LOAD, !rsp_valid)
   `BPC_ASSERT_IMP(a_scan_in_table, clock, reset, state_ff == ST_SCAN, row_ff <= n_last)
   `BPC_ASSERT_IMP(a_div_done_waiting, clock, reset, div_rsp.done, state_ff == ST_DIV)
   `BPC_ASSERT_NXT(a_frac_one_skip, clock, reset,
      state_ff == ST_FRAC && !div_req.start, state_ff == ST_MUL && frac_ff == FRAC_ONE)

endmodule

`default_nettype wire
